FILE: rtl/core/kmp_pkg.sv
// Package for the streaming KMP matcher: default depth, field codes and the
// command/status structs between controller and datapath. No dependencies.
package kmp_pkg;

  localparam int unsigned KMP_MAX_PATTERN = 64;

  localparam logic FUNC_PATTERN = 1'b0;
  localparam logic FUNC_TEXT    = 1'b1;

  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_NONE    = 1'b1;

  // controller -> datapath, one bit per controller step but the read wait
  typedef struct packed {
    logic take;   // beat accepted this cycle
    logic cmp;    // compare pattern byte against current byte
    logic fld;    // load j from failure table, reissue pattern read
    logic tfall;  // load j from failure table after a full match
    logic fin;    // retire text byte, load result if any
  } kmp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic take_search;  // accepted beat needs a search through the pattern
    logic fall;         // mismatch with j above zero: fall back
    logic build;        // current item is a pattern byte
    logic hit;          // full match on this compare
    logic stall;        // result pending but output register still full
  } kmp_status_t;

endpackage

FILE: rtl/core/kmp_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module kmp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/kmp_ctrl.sv
// Controller state machine of the KMP matcher: sequences accept, store reads,
// fallbacks and result retirement. Depends on kmp_pkg.
module kmp_ctrl import kmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  kmp_status_t st_i,
  output kmp_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_CMP   = 6'b000100,
    S_FLD   = 6'b001000,
    S_TFALL = 6'b010000,
    S_FIN   = 6'b100000
  } kmp_state_e;

  kmp_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (st_i.take_search) begin
            state_d = S_RD;
          end else if (st_i.build) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_RD: begin
        // pattern store read of j in flight
        state_d = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        if (st_i.fall) begin
          state_d = S_FLD;
        end else if (st_i.build) begin
          state_d = S_IDLE;
        end else if (st_i.hit) begin
          state_d = S_TFALL;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FLD: begin
        cmd_o.fld = 1'b1;
        state_d   = S_CMP;
      end
      S_TFALL: begin
        cmd_o.tfall = 1'b1;
        state_d     = S_FIN;
      end
      S_FIN: begin
        if (!st_i.stall) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  // a full match always leaves through the failure-table load
  a_hit_to_tfall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) && !st_i.fall && !st_i.build && st_i.hit |=> state_q == S_TFALL)
    else $error("full match did not go to failure load");
  // a stalled retire holds until the output register frees up
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) && st_i.stall |=> state_q == S_FIN)
    else $error("retire left while output register was full");
  // pattern bytes never reach the retire step
  a_build_no_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin |-> !st_i.build)
    else $error("pattern byte reached retire");
`endif

endmodule

FILE: rtl/core/kmp_dp.sv
// Datapath of the KMP matcher: pattern and failure stores, pointers, text
// offset and the output register. Depends on kmp_pkg and kmp_ram.
module kmp_dp import kmp_pkg::*; #(
  parameter int unsigned MAX_PATTERN = KMP_MAX_PATTERN
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  kmp_cmd_t    cmd_i,
  output kmp_status_t st_o,
  input  logic        func_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [31:0] position_o
);

  localparam int unsigned CW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [CW-1:0] PMAX = CW'(MAX_PATTERN);

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] bp_q, bp_d;
  logic [CW-1:0] mp_q, mp_d;
  logic [CW-1:0] j_q, j_d;
  logic [31:0]   off_q, off_d;
  logic          found_q, found_d;
  logic          closed_q, closed_d;
  logic          hit_q, hit_d;
  logic          func_q, last_q;
  logic [7:0]    byte_q;

  logic          out_valid_q, out_valid_d;
  logic          kind_q;
  logic [31:0]   pos_q;

  logic          ps_we, fs_we;
  logic [AW-1:0] ps_waddr, fs_waddr, ps_raddr, fs_raddr;
  logic [AW-1:0] fs_wdata;
  logic [7:0]    ps_rdata;
  logic [AW-1:0] fs_rdata;

  logic [CW-1:0] i_eff, jnew, jm1, cm1;
  logic          eq, fall, hit, res_needed;

  assign i_eff = closed_q ? '0 : count_q;
  assign eq    = (ps_rdata == byte_q);
  assign fall  = !eq && (j_q != '0);
  assign jnew  = eq ? j_q + CW'(1) : j_q;
  assign hit   = (func_q == FUNC_TEXT) && (jnew == count_q);
  assign jm1   = j_q - CW'(1);
  assign cm1   = count_q - CW'(1);

  assign res_needed = hit_q || (last_q && !found_q);

  assign st_o.take_search = (func_i == FUNC_TEXT) ? (count_q != '0)
                          : (!closed_q && (count_q != '0) && (count_q < PMAX));
  assign st_o.fall  = fall;
  assign st_o.build = cmd_i.take ? (func_i == FUNC_PATTERN) : (func_q == FUNC_PATTERN);
  assign st_o.hit   = hit;
  assign st_o.stall = res_needed && out_valid_q && !out_ready_i;

  // store ports
  assign ps_we    = cmd_i.take && (func_i == FUNC_PATTERN) && (i_eff < PMAX);
  assign ps_waddr = i_eff[AW-1:0];
  assign ps_raddr = cmd_i.fld ? fs_rdata : j_q[AW-1:0];

  always_comb begin
    fs_we    = 1'b0;
    fs_waddr = count_q[AW-1:0];
    fs_wdata = jnew[AW-1:0];
    if (ps_we && (i_eff == '0)) begin
      fs_we    = 1'b1;
      fs_waddr = '0;
      fs_wdata = '0;
    end else if (cmd_i.cmp && !fall && (func_q == FUNC_PATTERN)) begin
      fs_we = 1'b1;
    end
  end

  assign fs_raddr = hit ? cm1[AW-1:0] : jm1[AW-1:0];

  kmp_ram #(.WIDTH(8), .DEPTH(MAX_PATTERN)) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (ps_we),
    .waddr_i (ps_waddr),
    .wdata_i (data_byte_i),
    .raddr_i (ps_raddr),
    .rdata_o (ps_rdata)
  );

  kmp_ram #(.WIDTH(AW), .DEPTH(MAX_PATTERN)) u_fail_ram (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (fs_wdata),
    .raddr_i (fs_raddr),
    .rdata_o (fs_rdata)
  );

  always_comb begin
    count_d     = count_q;
    bp_d        = bp_q;
    mp_d        = mp_q;
    j_d         = j_q;
    off_d       = off_q;
    found_d     = found_q;
    closed_d    = closed_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.take) begin
      hit_d = 1'b0;
      if (func_i == FUNC_PATTERN) begin
        closed_d = last_i;
        if (closed_q) begin
          count_d = '0;
          bp_d    = '0;
          mp_d    = '0;
          off_d   = '0;
          found_d = 1'b0;
        end
        if (ps_we && (i_eff == '0)) begin
          bp_d    = '0;
          count_d = CW'(1);
        end
        j_d = bp_q;
      end else begin
        closed_d = 1'b1;
        j_d      = (mp_q >= count_q) ? '0 : mp_q;
      end
    end

    if (cmd_i.cmp && !fall) begin
      j_d = jnew;
      if (func_q == FUNC_PATTERN) begin
        bp_d    = jnew;
        count_d = count_q + CW'(1);
      end else if (hit) begin
        hit_d = 1'b1;
      end
    end

    if (cmd_i.fld || cmd_i.tfall) begin
      j_d = CW'(fs_rdata);
    end

    if (cmd_i.fin) begin
      if (res_needed) begin
        out_valid_d = 1'b1;
      end
      if (last_q) begin
        mp_d    = '0;
        off_d   = '0;
        found_d = 1'b0;
      end else begin
        mp_d    = j_q;
        off_d   = off_q + 32'd1;
        found_d = found_q || hit_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      bp_q        <= '0;
      mp_q        <= '0;
      j_q         <= '0;
      off_q       <= '0;
      found_q     <= 1'b0;
      closed_q    <= 1'b1;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      bp_q        <= bp_d;
      mp_q        <= mp_d;
      j_q         <= j_d;
      off_q       <= off_d;
      found_q     <= found_d;
      closed_q    <= closed_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item fields and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      func_q <= func_i;
      byte_q <= data_byte_i;
      last_q <= last_i;
    end
    if (cmd_i.fin && res_needed) begin
      kind_q <= hit_q ? KIND_MATCH : KIND_NONE;
      pos_q  <= hit_q ? (off_q + 32'd1 - 32'(count_q)) : 32'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign position_o  = pos_q;

`ifndef SYNTH
  // match pointer always stays below the pattern length between bytes
  a_mp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mp_q < count_q) || (mp_q == '0))
    else $error("match pointer out of range");
  // build pointer is a proper border of the stored pattern
  a_bp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bp_q < count_q) || (count_q == '0))
    else $error("build pointer out of range");
  // stored pattern never grows past the store depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= PMAX)
    else $error("pattern count beyond depth");
  // a match retired always shows up in the output register
  a_hit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin && hit_q |=> out_valid_q && (kind_q == KIND_MATCH))
    else $error("match result lost");
`endif

endmodule

FILE: rtl/core/kmp_stream_matcher_top.sv
// Streaming KMP matcher. Pattern byte: done on accept if it starts a pattern or
// is beyond depth, else read, compare and fallbacks. Text byte: retire on an
// empty pattern, else the same, a failure load on a full match, then retire;
// each fallback: a failure-table read then a pattern-store read, both registered
// RAM ports. Retire with a result due waits for a free output register; the
// result shows the cycle after retire. Reset clears pointers, flags, not stores.
module kmp_stream_matcher_top import kmp_pkg::*; #(
  parameter int unsigned MAX_PATTERN = KMP_MAX_PATTERN
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [31:0] position_o
);

  kmp_cmd_t    cmd;
  kmp_status_t st;

  kmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  kmp_dp #(.MAX_PATTERN(MAX_PATTERN)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .position_o  (position_o)
  );

endmodule
